// ----- design/ddws_pkg.sv -----
// ddws_pkg: types, codes and sizing constants for the date deque with search
// shared by ddws_cell, ddws_match_tree and date_deque_with_search_unit
// no dependencies
package ddws_pkg;

	localparam int DEPTH     = 64;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int OUT_CNT_W = 7;
	localparam int GROUP     = 8;
	localparam int N_GROUPS  = (DEPTH + GROUP - 1) / GROUP;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	typedef enum logic [2:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_BACK  = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_BACK   = 3'd3,
		MODE_FIND_YEAR  = 3'd4,
		MODE_FIND_MONTH = 3'd5,
		MODE_FIND_DATE  = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_FINAL
	} fsm_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} date_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [11:0] year_in;
		logic [3:0]  month_in;
		logic [4:0]  day_in;
	} in_word_t;

	typedef struct packed {
		logic                 found;
		logic [OUT_CNT_W-1:0] entry_count;
		logic [11:0]          front_year;
		logic [3:0]           front_month;
		logic [4:0]           front_day;
		logic [11:0]          back_year;
		logic [3:0]           back_month;
		logic [4:0]           back_day;
		logic [1:0]           status;
	} out_word_t;

	// command broadcast to every cell
	typedef struct packed {
		logic  shift_up;
		logic  shift_down;
		logic  search;
		logic  cmp_month;
		logic  cmp_day;
		date_t new_date;
	} cell_cmd_t;

endpackage

// ----- design/date_deque_with_search_unit.sv -----
// date_deque_with_search_unit: top level of the bounded date deque with search
// depends on ddws_pkg, ddws_cell, ddws_match_tree
//
// usage
// - request channel req/req_valid/req_ready: one word per operation (push front,
//   push back, pop front, pop back, find year, find year+month, find full date)
// - response channel rsp/rsp_valid/rsp_ready: exactly one word per request,
//   in request order
// - dates sit in a row of DEPTH cells, cell 0 is the front; push/pop at the
//   front shifts the whole row one cell, push at the back loads cell count
// - every cell compares against the key in parallel, the match flags go
//   through a registered or-tree of GROUP-wide groups
// a request is taken in ST_IDLE, where the cells update; ST_REDUCE captures
//   the or-tree and the back entry together; ST_FINAL loads the output register,
//   and no new request is taken until the sequencer is back in ST_IDLE
// a new request is taken while the previous response still waits in the
//   output register; if the receiver stalls longer, the pipeline holds in
//   its final stage and req_ready stays low
// reset: arst_n clears the entry count, the sequencer and rsp_valid; cell
//   contents need no reset since only occupied cells are ever read
module date_deque_with_search_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  ddws_pkg::in_word_t   req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output ddws_pkg::out_word_t  rsp
);
	import ddws_pkg::*;

	// sequencer and control state
	fsm_t            state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	status_t         status_s1, status_d;
	logic            accept;
	logic            rsp_load;

	// cell row
	cell_cmd_t       cmd;
	logic            push_back_en;
	date_t           cell_date [DEPTH];
	logic [DEPTH-1:0] cell_match;
	logic [DEPTH-1:0] cell_load;
	logic [DEPTH-1:0] cell_occ;
	logic            any_match;
	logic            tree_en;

	// back entry select and output word
	date_t           back_s2;
	logic [IDX_W-1:0] back_idx;
	date_t           front_date;
	out_word_t       rsp_q;
	logic            rsp_valid_q;

	assign accept = req_valid && req_ready;

	// request decode: cell command, count and status updates
	always_comb begin
		cmd              = '0;
		cmd.new_date     = '{year: req.year_in, month: req.month_in, day: req.day_in};
		push_back_en     = 1'b0;
		count_d          = count_q;
		status_d         = status_s1;
		if (accept) begin
			status_d = STAT_OK;
			case (mode_t'(req.mode))
				MODE_PUSH_FRONT: begin
					if (count_q == FULL_CNT) begin
						status_d = STAT_FULL;
					end else begin
						cmd.shift_up = 1'b1;
						count_d      = count_q + 1'b1;
					end
				end
				MODE_PUSH_BACK: begin
					if (count_q == FULL_CNT) begin
						status_d = STAT_FULL;
					end else begin
						push_back_en = 1'b1;
						count_d      = count_q + 1'b1;
					end
				end
				MODE_POP_FRONT: begin
					if (count_q == '0) begin
						status_d = STAT_EMPTY;
					end else begin
						cmd.shift_down = 1'b1;
						count_d        = count_q - 1'b1;
					end
				end
				MODE_POP_BACK: begin
					if (count_q == '0) begin
						status_d = STAT_EMPTY;
					end else begin
						count_d = count_q - 1'b1;
					end
				end
				MODE_FIND_YEAR: begin
					cmd.search = 1'b1;
				end
				MODE_FIND_MONTH: begin
					cmd.search    = 1'b1;
					cmd.cmp_month = 1'b1;
				end
				MODE_FIND_DATE: begin
					cmd.search    = 1'b1;
					cmd.cmp_month = 1'b1;
					cmd.cmp_day   = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// the chain: each cell takes its left neighbor on a front push and its
	// right neighbor on a front pop
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		date_t prev_d;
		date_t next_d;
		if (i == 0) begin : g_first
			assign prev_d = cmd.new_date;
		end else begin : g_mid_prev
			assign prev_d = cell_date[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_d = cell_date[i];
		end else begin : g_mid_next
			assign next_d = cell_date[i+1];
		end
		assign cell_occ[i]  = CNT_W'(i) < count_q;
		assign cell_load[i] = push_back_en && (IDX_W'(i) == count_q[IDX_W-1:0]);

		ddws_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.load      (cell_load[i]),
			.occupied  (cell_occ[i]),
			.prev_date (prev_d),
			.next_date (next_d),
			.date_q    (cell_date[i]),
			.match_q   (cell_match[i])
		);
	end

	// the or-tree captures the match flags once and holds them while the
	// final stage waits for the receiver
	assign tree_en = (state_q == ST_REDUCE);

	ddws_match_tree u_tree (
		.clk       (clk),
		.en        (tree_en),
		.match     (cell_match),
		.any_match (any_match)
	);

	// back entry sits at cell count-1 once the row has settled
	assign back_idx = IDX_W'(count_q - 1'b1);

	always_ff @(posedge clk) begin
		if (state_q == ST_REDUCE) begin
			back_s2 <= (count_q == '0) ? date_t'('0) : cell_date[back_idx];
		end
	end

	assign front_date = (count_q == '0) ? date_t'('0) : cell_date[0];

	// sequencer
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				state_d = ST_FINAL;
			end
			ST_FINAL: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			status_s1   <= STAT_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			status_s1 <= status_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.found       <= any_match;
			rsp_q.entry_count <= OUT_CNT_W'(count_q);
			rsp_q.front_year  <= front_date.year;
			rsp_q.front_month <= front_date.month;
			rsp_q.front_day   <= front_date.day;
			rsp_q.back_year   <= back_s2.year;
			rsp_q.back_month  <= back_s2.month;
			rsp_q.back_day    <= back_s2.day;
			rsp_q.status      <= status_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// entry count never runs past the row length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count exceeds depth");

	// a response word only appears out of the final stage
	a_rsp_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FINAL))
		else $error("response raised outside final stage");

	// a match can only come from an occupied row
	a_found_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL && any_match) |-> (count_q != '0))
		else $error("match reported on empty deque");

	// full refusal leaves the row full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL && status_s1 == STAT_FULL) |-> (count_q == FULL_CNT))
		else $error("full status with room left");

	// empty refusal leaves the row empty
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL && status_s1 == STAT_EMPTY) |-> (count_q == '0))
		else $error("empty status with entries stored");
`endif

endmodule

// ----- design/ddws_cell.sv -----
// ddws_cell: one storage cell of the date chain with its own comparator
// depends on ddws_pkg
module ddws_cell (
	input  logic              clk,
	input  ddws_pkg::cell_cmd_t cmd,
	input  logic              load,
	input  logic              occupied,
	input  ddws_pkg::date_t   prev_date,
	input  ddws_pkg::date_t   next_date,
	output ddws_pkg::date_t   date_q,
	output logic              match_q
);
	import ddws_pkg::*;

	logic hit;

	always_comb begin
		hit = (date_q.year == cmd.new_date.year)
			&& (!cmd.cmp_month || (date_q.month == cmd.new_date.month))
			&& (!cmd.cmp_day || (date_q.day == cmd.new_date.day));
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_up) begin
			date_q <= prev_date;
		end else if (cmd.shift_down) begin
			date_q <= next_date;
		end else if (load) begin
			date_q <= cmd.new_date;
		end
		match_q <= occupied && cmd.search && hit;
	end

endmodule

// ----- design/ddws_match_tree.sv -----
// ddws_match_tree: registered or-reduction of the per-cell match flags
// depends on ddws_pkg
module ddws_match_tree (
	input  logic             clk,
	input  logic             en,
	input  logic [ddws_pkg::DEPTH-1:0] match,
	output logic             any_match
);
	import ddws_pkg::*;

	// group flags only capture when enabled and hold otherwise
	logic [N_GROUPS-1:0] group_q;

	for (genvar g = 0; g < N_GROUPS; g++) begin : g_grp
		localparam int LO = g * GROUP;
		localparam int HI = (LO + GROUP > DEPTH) ? DEPTH - 1 : LO + GROUP - 1;
		always_ff @(posedge clk) begin
			if (en) begin
				group_q[g] <= |match[HI:LO];
			end
		end
	end

	assign any_match = |group_q;

endmodule

// ----- test/tb.sv -----
// tb: self-checking bench for date_deque_with_search_unit, drives request words and checks responses
// against an in-bench deque predictor under random idling and a long receiver hold-off
// depends on ddws_pkg and the date_deque_with_search_unit rtl
module tb;
	import ddws_pkg::*;

	// mode code the block must ignore (no state change, found 0, status ok)
	localparam logic [2:0] MODE_UNUSED = 3'd7;

	// watchdog: cycles with no word moving on either side before giving up
	localparam int QUIET_LIMIT = 2000;
	// long receiver hold-off, started once after this many response words
	localparam int HOLD_AT     = 150;
	localparam int HOLD_CYCLES = 80;
	// idling phases rotate every this many request words
	localparam int PHASE_LEN   = 60;
	// cycles allowed to drain after the last expected word has come back
	localparam int DRAIN_CYCLES = 12;

	typedef enum int {
		PH_NONE,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH,
		PH_QUIET
	} idle_phase_t;

	// operation mix of a random segment
	typedef enum int {
		MIX_EVEN,
		MIX_FILL,
		MIX_DRAIN
	} op_mix_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	in_word_t  req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	out_word_t rsp;

	// request words waiting to be offered, filled up front by the stimulus block
	in_word_t  pend_words[$];
	// response words the predictor has worked out, oldest first
	out_word_t answer_fifo[$];
	// predictor copy of the deque contents, index 0 is the front
	date_t     shadow_dates[$];
	// recently pushed dates, used to build search keys that hit
	date_t     recent_dates[$];

	int unsigned words_sent = 0;
	int unsigned words_back = 0;
	int unsigned mismatches = 0;
	int unsigned n_full = 0;
	int unsigned n_empty = 0;
	int unsigned n_hits = 0;
	int unsigned peak_fill = 0;
	int unsigned quiet_cycles = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	date_deque_with_search_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#4;
		clk = 1'b1;
		#4;
		clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// predictor: applies one request word to the shadow deque and
	// returns the response word the block should send for it
	// ---------------------------------------------------------------
	function automatic out_word_t apply_date_op(in_word_t w);
		out_word_t o;
		date_t     key;
		date_t     hd;
		date_t     tl;
		bit        year_eq;
		bit        month_eq;
		bit        day_eq;
		o = '0;
		key = {w.year_in, w.month_in, w.day_in};
		case (w.mode)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				// full store refuses the push and keeps everything as is
				if (shadow_dates.size() >= DEPTH) begin
					o.status = STAT_FULL;
					n_full++;
				end else if (w.mode == MODE_PUSH_FRONT)
					shadow_dates.push_front(key);
				else
					shadow_dates.push_back(key);
			end
			MODE_POP_FRONT, MODE_POP_BACK: begin
				// empty store refuses the pop
				if (shadow_dates.size() == 0) begin
					o.status = STAT_EMPTY;
					n_empty++;
				end else if (w.mode == MODE_POP_FRONT)
					void'(shadow_dates.pop_front());
				else
					void'(shadow_dates.pop_back());
			end
			MODE_FIND_YEAR, MODE_FIND_MONTH, MODE_FIND_DATE: begin
				// dates compare verbatim, out-of-calendar values included
				foreach (shadow_dates[i]) begin
					year_eq  = shadow_dates[i].year == key.year;
					month_eq = shadow_dates[i].month == key.month;
					day_eq   = shadow_dates[i].day == key.day;
					if (year_eq && (w.mode == MODE_FIND_YEAR ||
							(month_eq && (w.mode == MODE_FIND_MONTH || day_eq))))
						o.found = 1'b1;
				end
				if (o.found)
					n_hits++;
			end
			default: begin
				// unused mode: nothing changes
			end
		endcase
		if (shadow_dates.size() > peak_fill)
			peak_fill = shadow_dates.size();
		o.entry_count = OUT_CNT_W'(shadow_dates.size());
		// front and back read as all zero on an empty deque
		if (shadow_dates.size() != 0) begin
			hd = shadow_dates[0];
			tl = shadow_dates[$];
			o.front_year  = hd.year;
			o.front_month = hd.month;
			o.front_day   = hd.day;
			o.back_year   = tl.year;
			o.back_month  = tl.month;
			o.back_day    = tl.day;
		end
		return o;
	endfunction

	task automatic cmp_field(string fname, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
		end
	endtask

	task automatic check_word(out_word_t want, out_word_t got);
		cmp_field("found", want.found, got.found);
		cmp_field("entry_count", want.entry_count, got.entry_count);
		cmp_field("front_year", want.front_year, got.front_year);
		cmp_field("front_month", want.front_month, got.front_month);
		cmp_field("front_day", want.front_day, got.front_day);
		cmp_field("back_year", want.back_year, got.back_year);
		cmp_field("back_month", want.back_month, got.back_month);
		cmp_field("back_day", want.back_day, got.back_day);
		cmp_field("status", want.status, got.status);
	endtask

	// ---------------------------------------------------------------
	// idling: phase follows the number of request words sent so far
	// ---------------------------------------------------------------
	function automatic idle_phase_t idle_phase();
		return idle_phase_t'((words_sent / PHASE_LEN) % 5);
	endfunction

	function automatic bit sender_idles();
		case (idle_phase())
			PH_SEND_IDLE: return $urandom_range(0, 99) < 82;
			PH_BOTH:      return $urandom_range(0, 99) < 15;
			default:      return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_phase())
			PH_RECV_STALL: return $urandom_range(0, 99) < 82;
			PH_BOTH:       return $urandom_range(0, 99) < 15;
			default:       return 1'b0;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	// years come mostly from a short list so partial matches are common
	function automatic date_t rand_date();
		date_t d;
		logic [11:0] years[8] = '{12'd0, 12'd4095, 12'd2000, 12'd2024,
			12'd1970, 12'd1999, 12'd2100, 12'd1};
		d.year  = ($urandom_range(0, 99) < 60) ? years[$urandom_range(0, 7)]
			: 12'($urandom_range(0, 4095));
		// mostly calendar months, sometimes raw values outside it
		d.month = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 12))
			: 4'($urandom_range(0, 15));
		d.day   = 5'($urandom_range(0, 31));
		return d;
	endfunction

	// search key: often a recent date, sometimes with its day or month
	// scrambled, otherwise fully random
	function automatic date_t search_key();
		date_t k;
		date_t r;
		if (recent_dates.size() == 0 || $urandom_range(0, 99) < 35)
			return rand_date();
		k = recent_dates[$urandom_range(0, recent_dates.size() - 1)];
		r = rand_date();
		if ($urandom_range(0, 1))
			k.day = r.day;
		if ($urandom_range(0, 3) == 0)
			k.month = r.month;
		return k;
	endfunction

	task automatic queue_word(logic [2:0] m, date_t d);
		in_word_t w;
		w.mode     = m;
		w.year_in  = d.year;
		w.month_in = d.month;
		w.day_in   = d.day;
		pend_words.push_back(w);
		if (m == MODE_PUSH_FRONT || m == MODE_PUSH_BACK) begin
			recent_dates.push_back(d);
			if (recent_dates.size() > 16)
				void'(recent_dates.pop_front());
		end
	endtask

	task automatic queue_random(int count, op_mix_t mix);
		int push_pct;
		int pop_pct;
		int r;
		logic [2:0] m;
		push_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 10 : 35;
		pop_pct  = (mix == MIX_DRAIN) ? 70 : (mix == MIX_FILL) ? 10 : 30;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < push_pct) begin
				m = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
				queue_word(m, rand_date());
			end else if (r < push_pct + pop_pct) begin
				m = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
				queue_word(m, rand_date());
			end else if (r < 97) begin
				case ($urandom_range(0, 2))
					0:       m = MODE_FIND_YEAR;
					1:       m = MODE_FIND_MONTH;
					default: m = MODE_FIND_DATE;
				endcase
				queue_word(m, search_key());
			end else
				queue_word(MODE_UNUSED, rand_date());
		end
	endtask

	// ---------------------------------------------------------------
	// driver: offers pending words, holds a word until it is taken and
	// hands every taken word to the predictor
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready) begin
				answer_fifo.push_back(apply_date_op(req));
				words_sent++;
			end
			// a word still waiting keeps valid and payload as they are
			if (!req_valid || req_ready) begin
				if (pend_words.size() != 0 && !sender_idles()) begin
					req <= pend_words.pop_front();
					req_valid <= 1'b1;
				end else
					req_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: checks every response word against the oldest
	// prediction and drives rsp_ready, including one long hold-off
	// that backs the block up until it stops taking requests
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_ready <= 1'b0;
		else begin
			if (rsp_valid && rsp_ready) begin
				words_back++;
				if (answer_fifo.size() == 0) begin
					mismatches++;
					$display("%0t: response word with no request behind it, expected none actual %p",
						$time, rsp);
				end else
					check_word(answer_fifo.pop_front(), rsp);
			end
			if (!hold_done && words_back >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else
				rsp_ready <= !receiver_stalls();
		end
	end

	// watchdog: ends the run if neither side moves a word for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: watchdog, no word moved for %0d cycles, %0d predictions left",
				$time, QUIET_LIMIT, answer_fifo.size());
			$display("[date_deque_with_search_unit] ERROR");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// ---------------------------------------------------------------
	// stimulus and end of run
	// ---------------------------------------------------------------
	initial begin
		date_t all_ones;
		date_t all_zero;
		date_t eve;
		all_ones = {12'hFFF, 4'hF, 5'h1F};
		all_zero = '0;
		eve      = {12'd1999, 4'd12, 5'd31};

		// empty deque: refused pops, searches that cannot hit, unused mode
		queue_word(MODE_POP_FRONT, all_zero);
		queue_word(MODE_POP_BACK, all_ones);
		queue_word(MODE_FIND_YEAR, all_zero);
		queue_word(MODE_FIND_MONTH, all_ones);
		queue_word(MODE_FIND_DATE, all_zero);
		queue_word(MODE_UNUSED, all_ones);
		// field extremes, out-of-calendar month and day stored as given
		queue_word(MODE_PUSH_BACK, all_ones);
		queue_word(MODE_PUSH_FRONT, all_zero);
		queue_word(MODE_FIND_YEAR, {12'hFFF, 4'd0, 5'd0});
		queue_word(MODE_FIND_MONTH, {12'hFFF, 4'hF, 5'd1});
		queue_word(MODE_FIND_DATE, {12'hFFF, 4'hF, 5'd30});
		queue_word(MODE_FIND_DATE, all_zero);
		queue_word(MODE_FIND_MONTH, {12'd0, 4'd1, 5'd0});
		queue_word(MODE_UNUSED, eve);
		queue_word(MODE_PUSH_FRONT, eve);
		queue_word(MODE_FIND_YEAR, {12'd1999, 4'd1, 5'd1});
		// drain from both ends down to empty, then refuse once more
		queue_word(MODE_POP_FRONT, all_zero);
		queue_word(MODE_POP_BACK, all_zero);
		queue_word(MODE_POP_BACK, all_zero);
		queue_word(MODE_POP_FRONT, all_zero);
		queue_word(MODE_PUSH_BACK, eve);
		queue_word(MODE_FIND_DATE, eve);
		queue_word(MODE_POP_FRONT, all_zero);

		// random segments: fill phases run into the full store, drain phases
		// run into the empty one
		queue_random(80, MIX_EVEN);
		queue_random(150, MIX_FILL);
		queue_random(60, MIX_EVEN);
		queue_random(150, MIX_DRAIN);
		queue_random(100, MIX_FILL);
		queue_random(90, MIX_DRAIN);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait until every word is sent and every prediction answered
		do
			@(negedge clk);
		while (pend_words.size() != 0 || req_valid || answer_fifo.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (answer_fifo.size() != 0) begin
			mismatches++;
			$display("%0t: %0d predicted words never came back", $time, answer_fifo.size());
		end
		$display("run covered %0d request words, %0d responses checked, peak fill %0d of %0d",
			words_sent, words_back, peak_fill, DEPTH);
		$display("refused pushes on full %0d, refused pops on empty %0d, search hits %0d",
			n_full, n_empty, n_hits);
		if (mismatches == 0)
			$display("[date_deque_with_search_unit] OK");
		else
			$display("[date_deque_with_search_unit] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/ddws_pkg.sv
design/ddws_cell.sv
design/ddws_match_tree.sv
design/date_deque_with_search_unit.sv
test/tb.sv
